### rtl/core/task_timing_monitor_core_defines.svh
// Assertion macros for the task timing monitor RTL.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef TASK_TIMING_MONITOR_CORE_DEFINES_SVH
`define TASK_TIMING_MONITOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TTM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define TTM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/ttm_pkg.sv
// Shared types and constants of the task timing monitor.
// No dependencies.
package ttm_pkg;

  localparam int STAT_BITS_DEF = 16;
  localparam int TS_W          = 32;
  localparam int CNT_W         = 16;
  localparam int OUT_W         = 16;
  localparam int LOAD_W        = 7;
  localparam int DVD_W         = 40;
  localparam int DVS_W         = 32;

  localparam logic [1:0] KIND_TICK   = 2'd0;
  localparam logic [1:0] KIND_EVENT  = 2'd1;
  localparam logic [1:0] KIND_REPORT = 2'd2;

  localparam logic [1:0] SEL_AP = 2'd0;
  localparam logic [1:0] SEL_AB = 2'd1;
  localparam logic [1:0] SEL_AE = 2'd2;
  localparam logic [1:0] SEL_LD = 2'd3;

  localparam logic [TS_W-1:0]   ALL_ONES   = '1;
  localparam logic [CNT_W-1:0]  CNT_MAX    = '1;
  localparam logic [LOAD_W-1:0] LOAD_SCALE = 7'd100;

  typedef struct packed {
    logic       tick1;
    logic       tick2;
    logic       event_upd;
    logic       win_clear;
    logic       div_start;
    logic [1:0] div_sel;
    logic       div_capture;
    logic       load_mul;
    logic       out_load;
  } ttm_cmd_t;

  typedef struct packed {
    logic tick_zero;
    logic div_done;
  } ttm_sts_t;

endpackage

### rtl/core/ttm_div.sv
// Serial restoring divider, one quotient bit per cycle.
// Depends on ttm_pkg.
module ttm_div
  import ttm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CW = $clog2(DVD_W + 1);

  logic [DVS_W:0]   rem_r, rem_nxt;
  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [DVS_W-1:0] dvs_r;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   diff;

  always_comb begin
    shifted  = {rem_r[DVS_W-1:0], quo_r[DVD_W-1]};
    diff     = shifted - {1'b0, dvs_r};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = CW'(DVD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[DVS_W]) begin
        rem_nxt = diff;
        quo_nxt = {quo_r[DVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        quo_nxt = {quo_r[DVD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) dvs_r <= divisor;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

### rtl/core/ttm_datapath.sv
// Timing statistics registers, busy estimate, report arithmetic, result register.
// Depends on ttm_pkg and ttm_div.
module ttm_datapath
  import ttm_pkg::*;
#(
  parameter int STAT_BITS = STAT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ttm_cmd_t          cmd,
  output ttm_sts_t          sts,
  input  logic [TS_W-1:0]   now_us,
  output logic [OUT_W-1:0]  avg_period,
  output logic [OUT_W-1:0]  period_min,
  output logic [OUT_W-1:0]  period_max,
  output logic [OUT_W-1:0]  avg_busy,
  output logic [OUT_W-1:0]  busy_min,
  output logic [OUT_W-1:0]  busy_max,
  output logic [OUT_W-1:0]  avg_events,
  output logic [LOAD_W-1:0] load_percent
);

  localparam logic [32:0]        STAT_MAX  = (33'd1 << STAT_BITS) - 33'd1;
  localparam logic [STAT_BITS-1:0] STAT_TOP = STAT_MAX[STAT_BITS-1:0];

  function automatic logic [STAT_BITS-1:0] sat_stat(input logic [DVD_W-1:0] v);
    if (v > DVD_W'(STAT_MAX)) return STAT_TOP;
    else return v[STAT_BITS-1:0];
  endfunction

  function automatic logic [TS_W-1:0] add_sat(input logic [TS_W-1:0] a,
                                              input logic [TS_W-1:0] b);
    logic [TS_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TS_W] ? ALL_ONES : s[TS_W-1:0];
  endfunction

  function automatic logic [OUT_W-1:0] to_out(input logic [STAT_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[OUT_W-1:0];
  endfunction

  logic [CNT_W-1:0]     tick_cnt_r, ev_cnt_r;
  logic [TS_W-1:0]      last_tick_r, last_ev_r;
  logic [TS_W-1:0]      per_sum_r, busy_sum_r, ev_sum_r, gap_r;
  logic [STAT_BITS-1:0] pmin_r, pmax_r, bmin_r, bmax_r;
  logic [TS_W-1:0]      period_r;
  logic [47:0]          sub_r;
  logic [STAT_BITS-1:0] ap_r, ab_r, ae_r;
  logic [DVD_W-1:0]     ld_dvd_r;
  logic [LOAD_W-1:0]    load_r;

  logic [TS_W-1:0]      busy;
  logic [STAT_BITS-1:0] p_sat, b_sat, q_sat;
  logic [TS_W-1:0]      gap;
  logic [DVD_W-1:0]     dvd;
  logic [DVS_W-1:0]     dvs;
  logic [DVD_W-1:0]     quo;
  logic                 div_done;

  always_comb begin
    busy  = ({16'd0, period_r} > sub_r) ? TS_W'({16'd0, period_r} - sub_r) : '0;
    p_sat = sat_stat(DVD_W'(period_r));
    b_sat = sat_stat(DVD_W'(busy));
    q_sat = sat_stat(quo);
    gap   = now_us - last_ev_r;
    case (cmd.div_sel)
      SEL_AP:  dvd = DVD_W'(per_sum_r);
      SEL_AB:  dvd = DVD_W'(busy_sum_r);
      SEL_AE:  dvd = DVD_W'(ev_sum_r);
      default: dvd = ld_dvd_r;
    endcase
    dvs = (cmd.div_sel == SEL_LD) ? DVS_W'(ap_r) : DVS_W'(tick_cnt_r);
  end

  ttm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .done     (div_done),
    .quotient (quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_cnt_r  <= '0;
      ev_cnt_r    <= '0;
      last_tick_r <= '0;
      last_ev_r   <= '0;
      per_sum_r   <= '0;
      busy_sum_r  <= '0;
      ev_sum_r    <= '0;
      gap_r       <= ALL_ONES;
      pmin_r      <= STAT_TOP;
      pmax_r      <= '0;
      bmin_r      <= STAT_TOP;
      bmax_r      <= '0;
    end else begin
      if (cmd.tick1) last_tick_r <= now_us;
      if (cmd.tick2) begin
        per_sum_r  <= add_sat(per_sum_r, period_r);
        busy_sum_r <= add_sat(busy_sum_r, busy);
        ev_sum_r   <= add_sat(ev_sum_r, TS_W'(ev_cnt_r));
        if (p_sat < pmin_r) pmin_r <= p_sat;
        if (p_sat > pmax_r) pmax_r <= p_sat;
        if (b_sat < bmin_r) bmin_r <= b_sat;
        if (b_sat > bmax_r) bmax_r <= b_sat;
        if (tick_cnt_r != CNT_MAX) tick_cnt_r <= tick_cnt_r + CNT_W'(1);
        ev_cnt_r <= '0;
      end
      if (cmd.event_upd) begin
        if (ev_cnt_r != '0 && gap < gap_r) gap_r <= gap;
        last_ev_r <= now_us;
        if (ev_cnt_r != CNT_MAX) ev_cnt_r <= ev_cnt_r + CNT_W'(1);
      end
      if (cmd.win_clear) begin
        tick_cnt_r <= '0;
        per_sum_r  <= '0;
        busy_sum_r <= '0;
        ev_sum_r   <= '0;
        pmin_r     <= STAT_TOP;
        pmax_r     <= '0;
        bmin_r     <= STAT_TOP;
        bmax_r     <= '0;
      end
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk) begin
    if (cmd.tick1) begin
      period_r <= now_us - last_tick_r;
      // no gap measured yet: subtract nothing
      sub_r    <= (gap_r == ALL_ONES) ? '0 : 48'(ev_cnt_r) * 48'(gap_r);
    end
    if (cmd.div_capture) begin
      case (cmd.div_sel)
        SEL_AP:  ap_r <= (q_sat == '0) ? STAT_BITS'(1) : q_sat;
        SEL_AB:  ab_r <= q_sat;
        SEL_AE:  ae_r <= q_sat;
        default: load_r <= (quo > DVD_W'(LOAD_SCALE)) ? LOAD_SCALE : quo[LOAD_W-1:0];
      endcase
    end
    if (cmd.load_mul) ld_dvd_r <= DVD_W'(ab_r) * DVD_W'(LOAD_SCALE);
    if (cmd.out_load) begin
      avg_period   <= to_out(ap_r);
      period_min   <= to_out(pmin_r);
      period_max   <= to_out(pmax_r);
      avg_busy     <= to_out(ab_r);
      busy_min     <= to_out(bmin_r);
      busy_max     <= to_out(bmax_r);
      avg_events   <= to_out(ae_r);
      load_percent <= load_r;
    end
  end

  assign sts.tick_zero = (tick_cnt_r == '0);
  assign sts.div_done  = div_done;

endmodule

### rtl/core/ttm_ctrl.sv
// Sequencer of the task timing monitor: handshakes and report division order.
// Depends on ttm_pkg and the assertion macro header.
`include "task_timing_monitor_core_defines.svh"

module ttm_ctrl
  import ttm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_kind,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  output ttm_cmd_t   cmd,
  input  ttm_sts_t   sts
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_TICK2  = 3'd1;
  localparam logic [2:0] S_DSTART = 3'd2;
  localparam logic [2:0] S_DWAIT  = 3'd3;
  localparam logic [2:0] S_MUL    = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [1:0] sel_r, sel_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;

  // a new report waits until the pending result is taken
  assign in_stall = (state_r != S_IDLE) || (out_valid_r && in_kind == KIND_REPORT);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt     = state_r;
    sel_nxt       = sel_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.div_sel   = sel_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_kind)
            KIND_TICK: begin
              cmd.tick1 = 1'b1;
              state_nxt = S_TICK2;
            end
            KIND_EVENT: cmd.event_upd = 1'b1;
            KIND_REPORT: begin
              if (sts.tick_zero) begin
                cmd.win_clear = 1'b1;
              end else begin
                sel_nxt   = SEL_AP;
                state_nxt = S_DSTART;
              end
            end
            default: ;
          endcase
        end
      end
      S_TICK2: begin
        cmd.tick2 = 1'b1;
        state_nxt = S_IDLE;
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DWAIT;
      end
      S_DWAIT: begin
        if (sts.div_done) begin
          cmd.div_capture = 1'b1;
          case (sel_r)
            SEL_AP: begin
              sel_nxt   = SEL_AB;
              state_nxt = S_DSTART;
            end
            SEL_AB: begin
              sel_nxt   = SEL_AE;
              state_nxt = S_DSTART;
            end
            SEL_AE:  state_nxt = S_MUL;
            default: state_nxt = S_FINISH;
          endcase
        end
      end
      S_MUL: begin
        cmd.load_mul = 1'b1;
        sel_nxt      = SEL_LD;
        state_nxt    = S_DSTART;
      end
      S_FINISH: begin
        cmd.out_load  = 1'b1;
        cmd.win_clear = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sel_r       <= SEL_AP;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `TTM_ASSERT_NOW(a_busy_stalls, state_r != S_IDLE, in_stall, "input taken while busy")
  `TTM_ASSERT_NOW(a_no_pending_in_report, state_r == S_DSTART || state_r == S_DWAIT || state_r == S_MUL, !out_valid_r, "report running with result pending")
  `TTM_ASSERT_NEXT(a_result_from_finish, state_r != S_FINISH && !out_valid_r, !out_valid_r, "result without finished report")

endmodule

### rtl/core/task_timing_monitor_core.sv
// Task timing monitor: periodic ticks, event calls and report requests in, at most one
// statistics result per report out. A tick is taken on accept and finished in S_TICK2;
// an event is taken on accept. A report with ticks in its window runs four divisions on
// one shared 40-step serial divider (average period, busy and events by the tick count,
// then 100 x busy / period), each from its own start state, a multiply step before the
// last. A finish step loads the result. A report with no tick in its window gives no
// result and only clears the window. The result waits in an output register; ticks
// and events are taken meanwhile, while a further report is stalled until it leaves.
// Depends on ttm_pkg, ttm_ctrl and ttm_datapath.
module task_timing_monitor_core
  import ttm_pkg::*;
#(
  parameter int STAT_BITS = STAT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_kind,
  input  logic [TS_W-1:0]   in_now_us,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [OUT_W-1:0]  out_avg_period,
  output logic [OUT_W-1:0]  out_period_min,
  output logic [OUT_W-1:0]  out_period_max,
  output logic [OUT_W-1:0]  out_avg_busy,
  output logic [OUT_W-1:0]  out_busy_min,
  output logic [OUT_W-1:0]  out_busy_max,
  output logic [OUT_W-1:0]  out_avg_events,
  output logic [LOAD_W-1:0] out_load_percent
);

  ttm_cmd_t cmd;
  ttm_sts_t sts;

  ttm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_kind),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  ttm_datapath #(
    .STAT_BITS (STAT_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .now_us       (in_now_us),
    .avg_period   (out_avg_period),
    .period_min   (out_period_min),
    .period_max   (out_period_max),
    .avg_busy     (out_avg_busy),
    .busy_min     (out_busy_min),
    .busy_max     (out_busy_max),
    .avg_events   (out_avg_events),
    .load_percent (out_load_percent)
  );

endmodule

### bench/tb_task_timing_monitor_core.sv
// Testbench for task_timing_monitor_core: timestamped tick, event and report transfers in,
// report statistics out, checked against an in-bench load monitor model.
// Depends on ttm_pkg and the task_timing_monitor_core RTL.
typedef struct packed {
  logic [15:0] avg_period, period_min, period_max, avg_busy, busy_min, busy_max, avg_events;
  logic [6:0]  load_percent;
} report_t;

class load_scoreboard;
  report_t     pending_reports[$];
  int          mismatches;
  logic [31:0] ticks, events, last_tick, last_event, period_sum, busy_sum, event_sum, least_gap;
  logic [15:0] pmin, pmax, bmin, bmax;

  function new();
    mismatches = 0;
    clear_window();
    events = 0;
    last_tick = 0;
    last_event = 0;
    least_gap = '1;
  endfunction

  function void clear_window();
    ticks = 0;
    period_sum = 0;
    busy_sum = 0;
    event_sum = 0;
    pmin = 16'hFFFF;
    pmax = 0;
    bmin = 16'hFFFF;
    bmax = 0;
  endfunction

  function logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + b;
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function logic [15:0] sat16(logic [63:0] v);
    return v > 64'hFFFF ? 16'hFFFF : v[15:0];
  endfunction

  function void note_transfer(logic [1:0] kind, logic [31:0] now);
    logic [31:0] period, busy, gap;
    logic [63:0] sub;
    logic [15:0] p, b, ab;
    report_t r;
    if (kind == ttm_pkg::KIND_TICK) begin
      period = now - last_tick;
      last_tick = now;
      sub = (least_gap != '1) ? 64'(events) * least_gap : 64'd0;
      busy = (64'(period) > sub) ? 32'(64'(period) - sub) : 32'd0;
      period_sum = add_sat(period_sum, period);
      busy_sum = add_sat(busy_sum, busy);
      p = sat16(period);
      b = sat16(busy);
      if (p < pmin) pmin = p;
      if (p > pmax) pmax = p;
      if (b < bmin) bmin = b;
      if (b > bmax) bmax = b;
      if (ticks < 32'hFFFF) ticks++;
      event_sum = add_sat(event_sum, events);
      events = 0;
    end else if (kind == ttm_pkg::KIND_EVENT) begin
      if (events > 0) begin
        gap = now - last_event;
        if (gap < least_gap) least_gap = gap;
      end
      last_event = now;
      if (events < 32'hFFFF) events++;
    end else if (kind == ttm_pkg::KIND_REPORT) begin
      if (ticks > 0) begin
        r.avg_period = sat16(period_sum / ticks);
        if (r.avg_period < 1) r.avg_period = 1;
        ab = sat16(busy_sum / ticks);
        r.avg_busy = ab;
        r.avg_events = sat16(event_sum / ticks);
        r.period_min = pmin;
        r.period_max = pmax;
        r.busy_min = bmin;
        r.busy_max = bmax;
        r.load_percent = 7'((64'(ab) * 100 / r.avg_period) > 100 ? 100
                            : 64'(ab) * 100 / r.avg_period);
        pending_reports.push_back(r);
      end
      clear_window();
    end
  endfunction

  function void check_report(report_t got);
    report_t e;
    if (pending_reports.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected report transfer");
      return;
    end
    e = pending_reports.pop_front();
    if (got != e) begin
      mismatches++;
      if (mismatches <= 10)
        $display("report mismatch: exp %h %h %h %h %h %h %h %0d got %h %h %h %h %h %h %h %0d",
          e.avg_period, e.period_min, e.period_max, e.avg_busy, e.busy_min, e.busy_max,
          e.avg_events, e.load_percent, got.avg_period, got.period_min, got.period_max,
          got.avg_busy, got.busy_min, got.busy_max, got.avg_events, got.load_percent);
    end
  endfunction
endclass

module tb_task_timing_monitor_core;
  import ttm_pkg::*;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [1:0]  in_kind = 0;
  logic [31:0] in_now_us = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [15:0] out_avg_period, out_period_min, out_period_max, out_avg_busy;
  logic [15:0] out_busy_min, out_busy_max, out_avg_events;
  logic [6:0]  out_load_percent;

  load_scoreboard sb = new();
  logic [31:0] clock_us = 0;
  int          stall_mode = 0;

  task_timing_monitor_core i_dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // receiver stall pattern: phases of none, light, heavy
  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_stall <= 0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk) begin
    report_t r;
    if (rst_n && out_valid && !out_stall) begin
      r.avg_period = out_avg_period;
      r.period_min = out_period_min;
      r.period_max = out_period_max;
      r.avg_busy = out_avg_busy;
      r.busy_min = out_busy_min;
      r.busy_max = out_busy_max;
      r.avg_events = out_avg_events;
      r.load_percent = out_load_percent;
      sb.check_report(r);
    end
  end

  // one transfer; the caller decides gaps
  task automatic send(logic [1:0] kind, logic [31:0] now);
    in_valid <= 1;
    in_kind <= kind;
    in_now_us <= now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_transfer(kind, now);
  endtask

  task automatic idle(int n);
    in_valid <= 0;
    repeat (n) @(posedge clk);
  endtask

  task automatic advance_and_send(logic [1:0] kind, int step);
    clock_us = clock_us + step;
    send(kind, clock_us);
  endtask

  initial begin
    int count, burst, nev, step;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: empty report, no-gap tick, wraps, saturation, kind 3
    send(KIND_REPORT, 0);
    send(KIND_TICK, 32'd100);
    send(KIND_EVENT, 32'd150);
    send(KIND_TICK, 32'd300);
    send(KIND_EVENT, 32'd310);
    send(KIND_EVENT, 32'd400);
    send(KIND_EVENT, 32'd500);
    send(KIND_TICK, 32'd600);
    send(KIND_EVENT, 32'd610);
    send(KIND_TICK, 32'd615);
    send(2'd3, 32'hFFFF_FFFF);
    send(KIND_REPORT, 32'd700);
    send(KIND_TICK, 32'hFFFF_FFFF);
    send(KIND_TICK, 32'h0000_0010);
    send(KIND_TICK, 32'h0000_0010);
    send(KIND_EVENT, 32'hFFFF_FFF0);
    send(KIND_EVENT, 32'h0000_0005);
    send(KIND_TICK, 32'h8000_0000);
    send(KIND_REPORT, 32'h8000_0001);
    send(KIND_TICK, 32'hAAAA_AAAA);
    send(KIND_TICK, 32'h5555_5555);
    send(KIND_REPORT, 32'h5555_5556);
    clock_us = 32'h5555_6000;

    count = 0;
    while (count < 1850) begin
      burst = $urandom_range(1, 20);
      repeat (burst) begin
        case ($urandom_range(0, 19))
          0: begin
            send(2'($urandom_range(0, 3)), $urandom);
          end
          1, 2: advance_and_send(KIND_REPORT, $urandom_range(0, 50));
          3, 4, 5, 6, 7, 8: begin
            nev = $urandom_range(0, 4);
            repeat (nev) advance_and_send(KIND_EVENT, $urandom_range(1, 300));
            step = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1, 3000);
            advance_and_send(KIND_TICK, step);
            count += nev;
          end
          default: advance_and_send(2'($urandom_range(0, 1)), $urandom_range(0, 2500));
        endcase
        count++;
      end
      if ($urandom_range(0, 2) != 0) idle($urandom_range(1, 30));
    end
    in_valid <= 0;

    count = 0;
    while (sb.pending_reports.size() != 0 && count < 100000) begin
      @(posedge clk);
      count++;
    end
    repeat (400) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_reports.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #50000000;
    $display("Regression FAIL");
    $finish;
  end
endmodule
